>>> hw/rtl/load_current_estimator_assert.svh
// ----------------------------------------------------------------------------
// load_current_estimator_assert
// assertion macros for the load current estimator
// ----------------------------------------------------------------------------
`ifndef LOAD_CURRENT_ESTIMATOR_ASSERT_SVH
`define LOAD_CURRENT_ESTIMATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// property holds in the same cycle
`define LCE_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
// property holds in the cycle after the antecedent
`define LCE_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define LCE_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg)
`define LCE_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg)
`endif
`endif

>>> hw/rtl/lce_pkg.sv
// ----------------------------------------------------------------------------
// lce_pkg
// shared types and constants of the load current estimator
// ----------------------------------------------------------------------------
package lce_pkg;

    // default catalog depth
    localparam int CATALOG_DEPTH = 64;

    // fixed point constants
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;
    localparam logic [15:0] ONE_Q15   = 16'd32768;

    // datapath widths
    localparam int VE_W   = 40;  // voltage * efficiency
    localparam int VEC_W  = 56;  // voltage * efficiency * cos_phi
    localparam int DEN_W  = 71;  // divisor, three-phase worst case
    localparam int NUM_W  = 85;  // dividend, power shifted left by 54
    localparam int PROD_W = 63;  // interpolation product

    // commands
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_FORMULA = 2'd1,
        CMD_CATALOG = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_INVALID  = 3'd1,
        STS_NOT_3PH  = 3'd2,
        STS_UNSORTED = 3'd3,
        STS_SAT      = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SCAN,
        S_DECIDE,
        S_IMUL,
        S_DSTART,
        S_DWAIT,
        S_FIN
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> hw/rtl/lce_div.sv
// ----------------------------------------------------------------------------
// lce_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lce_div #(
    parameter int NUM_W = lce_pkg::NUM_W,
    parameter int DEN_W = lce_pkg::DEN_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output lce_pkg::t_div_sts     o_sts,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;

    // trial subtract of the shifted remainder
    always_comb begin
        sh   = {r_rem, r_q[NUM_W-1]};
        diff = sh - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!diff[DEN_W]) begin
                r_rem <= diff[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

>>> hw/rtl/load_current_estimator.sv
// ----------------------------------------------------------------------------
// load_current_estimator
// current of an electrical load from a formula or from a stored catalog
// ----------------------------------------------------------------------------
// Input channel i_valid / o_stall carries one command item: load a catalog
// entry, compute the formula current, or estimate from the catalog. Output
// channel o_valid / i_stall returns one item (current, status) per command.
// The catalog size register is written through i_cfg_valid / o_cfg_ready.
// Items are processed one at a time; o_stall is high while one is at work.
// Load commands and rejected items go straight to the finish state.
// Formula: states MUL1, MUL2 and, for three phases, MUL3, then the divider.
// Catalog: one table read per cycle over the n entries, then a decide state
// and, unless clamped at an end or unsorted, a multiply state and the divider.
// The bit-serial divider shared by both modes sets the pace.
// A finished result sits in an output register; the next item is accepted
// while it waits, and a further result holds until i_stall drops.
// Reset clears the sequencer, the output valid and sets catalog size to 1;
// the catalog memory keeps its contents and must be loaded before use.
// ----------------------------------------------------------------------------
`include "load_current_estimator_assert.svh"

module load_current_estimator #(
    parameter int CATALOG_DEPTH = lce_pkg::CATALOG_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_power,
    input  logic [23:0]        i_voltage,
    input  logic [15:0]        i_cos_phi,
    input  logic [15:0]        i_efficiency,
    input  logic               i_three_phase,
    input  logic [5:0]         i_entry_index,
    input  logic [30:0]        i_entry_power,
    input  logic [31:0]        i_entry_current,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_current,
    output logic [2:0]         o_status,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data
);

    localparam int AW     = $clog2(CATALOG_DEPTH);
    localparam int CW     = $clog2(CATALOG_DEPTH + 1);
    localparam int NUM_W  = lce_pkg::NUM_W;
    localparam int DEN_W  = lce_pkg::DEN_W;
    localparam int VE_W   = lce_pkg::VE_W;
    localparam int VEC_W  = lce_pkg::VEC_W;
    localparam int PROD_W = lce_pkg::PROD_W;

    lce_pkg::t_state   r_state, n_state;
    lce_pkg::t_div_sts div_sts;
    logic [NUM_W-1:0]  div_quot;
    logic [NUM_W-1:0]  div_num;
    logic              div_start;

    logic              in_acc;
    logic              push;
    logic              form_ok;
    logic              scan_end;
    logic [CW-1:0]     cat_n;

    // configuration and output registers
    logic [6:0]        r_cat_size;
    logic              r_ovld;
    logic [31:0]       r_ocur;
    lce_pkg::t_status  r_osts;

    // item registers
    logic              r_is_formula;
    logic              r_three;
    logic [30:0]       r_up;
    logic [23:0]       r_v;
    logic [15:0]       r_c;
    logic [15:0]       r_e;
    logic [DEN_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic [31:0]       r_res_cur;
    lce_pkg::t_status  r_res_sts;

    // scan registers
    logic [CW-1:0]     r_ridx;
    logic [CW-1:0]     r_didx;
    logic              r_dvld;
    logic              r_bad;
    logic              r_found;
    logic              r_kzero;
    logic [30:0]       r_prev_pow;
    logic [31:0]       r_prev_cur;
    logic [30:0]       r_p1;
    logic [30:0]       r_p2;
    logic [31:0]       r_c1;
    logic [31:0]       r_c2;
    logic [30:0]       r_dp;
    logic [31:0]       r_dc;
    logic              r_dec;

    // catalog memory
    logic [30:0]       mem_pow [CATALOG_DEPTH];
    logic [31:0]       mem_cur [CATALOG_DEPTH];
    logic [30:0]       r_rd_pow;
    logic [31:0]       r_rd_cur;

    assign in_acc      = i_valid && !o_stall;
    assign push        = (r_state == lce_pkg::S_FIN) && (!r_ovld || !i_stall);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovld;
    assign o_current   = r_ocur;
    assign o_status    = r_osts;

    // formula argument check
    assign form_ok = !i_power[31] && (i_voltage != '0)
                  && (i_cos_phi != '0) && (i_cos_phi <= lce_pkg::ONE_Q15)
                  && (i_efficiency != '0) && (i_efficiency <= lce_pkg::ONE_Q15);

    // effective catalog size
    always_comb begin
        if (r_cat_size == '0) begin
            cat_n = CW'(1);
        end else if (32'(r_cat_size) > CATALOG_DEPTH) begin
            cat_n = CW'(CATALOG_DEPTH);
        end else begin
            cat_n = CW'(r_cat_size);
        end
    end

    assign scan_end = r_dvld && (r_didx == cat_n - CW'(1));

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cat_size <= 7'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cat_size <= i_cfg_data;
        end
    end

    // catalog write and registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && (lce_pkg::t_cmd'(i_command) == lce_pkg::CMD_LOAD)
                && (32'(i_entry_index) < CATALOG_DEPTH)) begin
            mem_pow[AW'(i_entry_index)] <= i_entry_power;
            mem_cur[AW'(i_entry_index)] <= i_entry_current;
        end
        r_rd_pow <= mem_pow[r_ridx[AW-1:0]];
        r_rd_cur <= mem_cur[r_ridx[AW-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lce_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (lce_pkg::t_cmd'(i_command))
                        lce_pkg::CMD_FORMULA: begin
                            n_state = form_ok ? lce_pkg::S_MUL1 : lce_pkg::S_FIN;
                        end
                        lce_pkg::CMD_CATALOG: begin
                            n_state = (i_three_phase && !i_power[31] && (i_power != '0))
                                    ? lce_pkg::S_SCAN : lce_pkg::S_FIN;
                        end
                        lce_pkg::CMD_LOAD,
                        lce_pkg::CMD_RSVD: begin
                            n_state = lce_pkg::S_FIN;
                        end
                    endcase
                end
            end
            lce_pkg::S_MUL1: begin
                n_state = lce_pkg::S_MUL2;
            end
            lce_pkg::S_MUL2: begin
                n_state = r_three ? lce_pkg::S_MUL3 : lce_pkg::S_DSTART;
            end
            lce_pkg::S_MUL3: begin
                n_state = lce_pkg::S_DSTART;
            end
            lce_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = lce_pkg::S_DECIDE;
                end
            end
            lce_pkg::S_DECIDE: begin
                n_state = (r_bad || !r_found || r_kzero) ? lce_pkg::S_FIN : lce_pkg::S_IMUL;
            end
            lce_pkg::S_IMUL: begin
                n_state = lce_pkg::S_DSTART;
            end
            lce_pkg::S_DSTART: begin
                n_state = lce_pkg::S_DWAIT;
            end
            lce_pkg::S_DWAIT: begin
                if (div_sts.done) begin
                    n_state = lce_pkg::S_FIN;
                end
            end
            lce_pkg::S_FIN: begin
                if (push) begin
                    n_state = lce_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lce_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall   = (r_state != lce_pkg::S_IDLE);
        div_start = (r_state == lce_pkg::S_DSTART);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lce_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (push) begin
            r_ovld <= 1'b1;
        end else if (r_ovld && !i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ocur <= r_res_cur;
            r_osts <= r_res_sts;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= 1'b0;
        end else if (r_state == lce_pkg::S_SCAN && r_ridx < cat_n) begin
            r_dvld <= 1'b1;
        end else begin
            r_dvld <= 1'b0;
        end
    end

    // divider operands
    always_comb begin
        if (r_is_formula) begin
            div_num = r_three ? NUM_W'({r_up, 54'd0}) : NUM_W'({r_up, 38'd0});
        end else begin
            div_num = NUM_W'(r_prod);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            lce_pkg::S_IDLE: begin
                r_up         <= i_power[30:0];
                r_v          <= i_voltage;
                r_c          <= i_cos_phi;
                r_e          <= i_efficiency;
                r_three      <= i_three_phase;
                r_is_formula <= (lce_pkg::t_cmd'(i_command) == lce_pkg::CMD_FORMULA);
                r_ridx       <= '0;
                r_bad        <= 1'b0;
                r_found      <= 1'b0;
                r_kzero      <= 1'b0;
                r_res_cur    <= '0;
                case (lce_pkg::t_cmd'(i_command))
                    lce_pkg::CMD_LOAD: begin
                        r_res_sts <= lce_pkg::STS_OK;
                    end
                    lce_pkg::CMD_FORMULA: begin
                        r_res_sts <= form_ok ? lce_pkg::STS_OK : lce_pkg::STS_INVALID;
                    end
                    lce_pkg::CMD_CATALOG: begin
                        if (!i_three_phase) begin
                            r_res_sts <= lce_pkg::STS_NOT_3PH;
                        end else if (i_power[31]) begin
                            r_res_sts <= lce_pkg::STS_INVALID;
                        end else begin
                            r_res_sts <= lce_pkg::STS_OK;
                        end
                    end
                    default: begin
                        r_res_sts <= lce_pkg::STS_INVALID;
                    end
                endcase
            end
            lce_pkg::S_MUL1: begin
                r_acc <= DEN_W'(VE_W'(r_v) * VE_W'(r_e));
            end
            lce_pkg::S_MUL2: begin
                r_acc <= DEN_W'(VEC_W'(r_acc[VE_W-1:0]) * VEC_W'(r_c));
            end
            lce_pkg::S_MUL3: begin
                r_acc <= DEN_W'(r_acc[VEC_W-1:0]) * DEN_W'(lce_pkg::SQRT3_Q16);
            end
            lce_pkg::S_SCAN: begin
                if (r_ridx < cat_n) begin
                    r_didx <= r_ridx;
                    r_ridx <= r_ridx + CW'(1);
                end
                if (r_dvld) begin
                    // ordering check against the previous entry
                    if (r_didx != '0 && r_prev_pow > r_rd_pow) begin
                        r_bad <= 1'b1;
                    end
                    // first entry at or above the target
                    if (!r_found && r_rd_pow >= r_up) begin
                        r_found <= 1'b1;
                        r_kzero <= (r_didx == '0);
                        r_p1    <= r_prev_pow;
                        r_c1    <= r_prev_cur;
                        r_p2    <= r_rd_pow;
                        r_c2    <= r_rd_cur;
                    end
                    r_prev_pow <= r_rd_pow;
                    r_prev_cur <= r_rd_cur;
                end
            end
            lce_pkg::S_DECIDE: begin
                if (r_bad) begin
                    r_res_cur <= '0;
                    r_res_sts <= lce_pkg::STS_UNSORTED;
                end else if (!r_found) begin
                    r_res_cur <= r_prev_cur;
                end else if (r_kzero) begin
                    r_res_cur <= r_c2;
                end
                r_dp  <= r_up - r_p1;
                r_dec <= (r_c2 < r_c1);
                r_dc  <= (r_c2 >= r_c1) ? (r_c2 - r_c1) : (r_c1 - r_c2);
            end
            lce_pkg::S_IMUL: begin
                r_prod <= PROD_W'(r_dp) * PROD_W'(r_dc);
                r_acc  <= DEN_W'(r_p2 - r_p1);
            end
            lce_pkg::S_DWAIT: begin
                if (div_sts.done) begin
                    if (r_is_formula) begin
                        if (div_quot[NUM_W-1:32] != '0) begin
                            r_res_cur <= '1;
                            r_res_sts <= lce_pkg::STS_SAT;
                        end else begin
                            r_res_cur <= div_quot[31:0];
                        end
                    end else begin
                        r_res_cur <= r_dec ? (r_c1 - div_quot[31:0])
                                           : (r_c1 + div_quot[31:0]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // shared divider
    lce_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_acc),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // checks
    `LCE_ASSERT_NOW(a_zero_on_error, i_clk, i_rst_n,
        o_valid && (o_status != lce_pkg::STS_OK) && (o_status != lce_pkg::STS_SAT),
        o_current == '0, "current not zero on an error status")
    `LCE_ASSERT_NOW(a_div_in_wait, i_clk, i_rst_n,
        div_sts.busy, r_state == lce_pkg::S_DWAIT, "divider busy outside its wait state")
    `LCE_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n,
        push, o_valid, "finished item did not reach the output")

endmodule

>>> tb/lce_result_checker.sv
// ----------------------------------------------------------------------------
// lce_result_checker
// predicts and checks every result item of the load current estimator
// ----------------------------------------------------------------------------
// Watches the command, result and configuration channels at the rising clock
// edge. Each accepted command item is run through a local copy of the
// estimator (catalog table, catalog size, formula and interpolation) and the
// expected item is queued. Every accepted result item is compared with the
// oldest queued one. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module lce_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_power,
    input  logic [23:0]        i_voltage,
    input  logic [15:0]        i_cos_phi,
    input  logic [15:0]        i_efficiency,
    input  logic               i_three_phase,
    input  logic [5:0]         i_entry_index,
    input  logic [30:0]        i_entry_power,
    input  logic [31:0]        i_entry_current,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_current,
    input  logic [2:0]         i_status,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [6:0]         i_cfg_data,
    output int                 o_mismatches,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]      current;
        lce_pkg::t_status status;
    } t_result;

    logic [30:0] cat_power [lce_pkg::CATALOG_DEPTH];
    logic [31:0] cat_current [lce_pkg::CATALOG_DEPTH];
    logic [6:0]  cat_size;
    t_result     expected_results [$];
    int          mismatch_cnt;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = expected_results.size();

    // formula current: P / (V * eff * k * cosPhi), truncated, saturating
    function automatic t_result formula_current(logic signed [31:0] p, logic [23:0] v,
                                                logic [15:0] c, logic [15:0] e,
                                                logic three);
        t_result      r;
        logic [63:0]  vec;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        r = '{current: '0, status: lce_pkg::STS_OK};
        if (p < 0 || v == '0 || c == '0 || c > lce_pkg::ONE_Q15 || e == '0
                || e > lce_pkg::ONE_Q15) begin
            r.status = lce_pkg::STS_INVALID;
            return r;
        end
        vec = 64'(v) * 64'(e) * 64'(c);
        if (three) begin
            num = 128'(p) << 54;
            den = 128'(vec) * 128'(lce_pkg::SQRT3_Q16);
        end else begin
            num = 128'(p) << 38;
            den = 128'(vec);
        end
        quo = num / den;
        if (quo > 128'h0FFFF_FFFF) begin
            r.current = '1;
            r.status  = lce_pkg::STS_SAT;
        end else begin
            r.current = quo[31:0];
        end
        return r;
    endfunction

    // catalog lookup with end clamping and linear interpolation
    function automatic t_result catalog_current(logic signed [31:0] p, logic three);
        t_result     r;
        int          n;
        int          k;
        logic [63:0] up;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] c1;
        logic [63:0] c2;
        logic [63:0] q;
        r = '{current: '0, status: lce_pkg::STS_OK};
        n = int'(cat_size);
        if (n < 1) n = 1;
        if (n > lce_pkg::CATALOG_DEPTH) n = lce_pkg::CATALOG_DEPTH;
        if (!three) begin
            r.status = lce_pkg::STS_NOT_3PH;
            return r;
        end
        if (p < 0) begin
            r.status = lce_pkg::STS_INVALID;
            return r;
        end
        if (p == '0) return r;
        for (int i = 1; i < n; i++) begin
            if (cat_power[i-1] > cat_power[i]) begin
                r.status = lce_pkg::STS_UNSORTED;
                return r;
            end
        end
        up = 64'(p);
        k  = n;
        for (int i = 0; i < n; i++) begin
            if (64'(cat_power[i]) >= up) begin
                k = i;
                break;
            end
        end
        if (k == 0) begin
            r.current = cat_current[0];
        end else if (k == n) begin
            r.current = cat_current[n-1];
        end else begin
            p1 = 64'(cat_power[k-1]);
            p2 = 64'(cat_power[k]);
            c1 = 64'(cat_current[k-1]);
            c2 = 64'(cat_current[k]);
            if (c2 >= c1) begin
                q = ((up - p1) * (c2 - c1)) / (p2 - p1);
                r.current = 32'(c1 + q);
            end else begin
                q = ((up - p1) * (c1 - c2)) / (p2 - p1);
                r.current = 32'(c1 - q);
            end
        end
        return r;
    endfunction

    // track config, predict accepted items, compare returned items
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cat_size <= 7'd1;
            expected_results.delete();
            mismatch_cnt <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) cat_size <= i_cfg_data;
            if (i_valid && !i_stall_in) begin
                case (lce_pkg::t_cmd'(i_command))
                    lce_pkg::CMD_LOAD: begin
                        cat_power[i_entry_index]   <= i_entry_power;
                        cat_current[i_entry_index] <= i_entry_current;
                        expected_results.push_back('{current: '0,
                                                     status: lce_pkg::STS_OK});
                    end
                    lce_pkg::CMD_FORMULA: expected_results.push_back(formula_current(
                        i_power, i_voltage, i_cos_phi, i_efficiency, i_three_phase));
                    lce_pkg::CMD_CATALOG: expected_results.push_back(
                        catalog_current(i_power, i_three_phase));
                    default: expected_results.push_back('{current: '0,
                                                          status: lce_pkg::STS_INVALID});
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{current: i_current, status: lce_pkg::t_status'(i_status)};
                if (expected_results.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("unexpected result item: current %h status %0d",
                                 i_current, i_status);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("mismatch: current exp %h got %h, status exp %0d got %0d",
                                     want.current, got.current, want.status, i_status);
                    end
                end
            end
        end
    end
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the load current estimator
// ----------------------------------------------------------------------------
// Fills the catalog, runs directed formula and catalog cases, then about 1200
// random items over several catalog sizes with random idling on both sides,
// a long result hold-off and drained pauses. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_command;
    logic signed [31:0] i_power;
    logic [23:0]        i_voltage;
    logic [15:0]        i_cos_phi;
    logic [15:0]        i_efficiency;
    logic               i_three_phase;
    logic [5:0]         i_entry_index;
    logic [30:0]        i_entry_power;
    logic [31:0]        i_entry_current;
    logic               o_valid;
    logic               i_stall;
    logic [31:0]        o_current;
    logic [2:0]         o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [6:0]         i_cfg_data;

    int mismatches;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cnt;
    bit hold_req;
    int quiet_cycles;
    logic [30:0] slot_power [lce_pkg::CATALOG_DEPTH];

    load_current_estimator dut (.*);

    lce_result_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_command, .i_power,
        .i_voltage, .i_cos_phi, .i_efficiency, .i_three_phase, .i_entry_index,
        .i_entry_power, .i_entry_current, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_current(o_current), .i_status(o_status), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_data, .o_mismatches(mismatches), .o_pending(pending)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // receiver stalls, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[load_current_estimator] ERROR");
            $finish;
        end
    end

    // offer one item and wait for it to be taken
    task automatic send_item(lce_pkg::t_cmd cmd, logic signed [31:0] p, logic [23:0] v,
                             logic [15:0] c, logic [15:0] e, logic three,
                             logic [5:0] idx, logic [30:0] ep, logic [31:0] ec);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_power         <= p;
        i_voltage       <= v;
        i_cos_phi       <= c;
        i_efficiency    <= e;
        i_three_phase   <= three;
        i_entry_index   <= idx;
        i_entry_power   <= ep;
        i_entry_current <= ec;
        if (cmd == lce_pkg::CMD_LOAD) slot_power[idx] = ep;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // let everything drain, then write the catalog size
    task automatic set_catalog_size(logic [6:0] size);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // power of a slot that keeps the table ascending
    function automatic logic [30:0] sorted_power(int idx);
        return 31'(idx * 32'h0200_0000 + $urandom_range(32'h01FF_FFFF));
    endfunction

    task automatic load_slot(int idx, logic [30:0] ep);
        send_item(lce_pkg::CMD_LOAD, $urandom, 24'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom), 6'(idx), ep, $urandom);
    endtask

    // one random item, mostly well formed
    task automatic random_item();
        int          sel;
        int          idx;
        logic [30:0] ep;
        logic signed [31:0] p;
        logic [15:0] c;
        logic [15:0] e;
        sel = $urandom_range(99);
        if (sel < 25) begin
            idx = $urandom_range(lce_pkg::CATALOG_DEPTH - 1);
            case ($urandom_range(9))
                0: ep = 31'($urandom);
                1: ep = (idx > 0) ? slot_power[idx-1] : 31'd0;
                default: ep = sorted_power(idx);
            endcase
            load_slot(idx, ep);
        end else if (sel < 62) begin
            p = ($urandom_range(9) == 0) ? $signed($urandom) :
                $signed({1'b0, 31'($urandom >> $urandom_range(31))});
            c = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32768));
            e = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32768));
            send_item(lce_pkg::CMD_FORMULA, p, ($urandom_range(19) == 0) ? 24'd0 :
                      24'($urandom >> $urandom_range(8, 31)), c, e, 1'($urandom),
                      6'($urandom), 31'($urandom), $urandom);
        end else if (sel < 96) begin
            case ($urandom_range(19))
                0: p = $signed($urandom) | 32'sh8000_0000;
                1: p = '0;
                default: p = $signed({1'b0, 31'($urandom)});
            endcase
            send_item(lce_pkg::CMD_CATALOG, p, 24'($urandom), 16'($urandom), 16'($urandom),
                      ($urandom_range(14) != 0), 6'($urandom), 31'($urandom), $urandom);
        end else begin
            send_item(lce_pkg::CMD_RSVD, $urandom, 24'($urandom), 16'($urandom),
                      16'($urandom), 1'($urandom), 6'($urandom), 31'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [6:0] sizes [6];
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_command       <= lce_pkg::CMD_LOAD;
        i_power         <= '0;
        i_voltage       <= '0;
        i_cos_phi       <= '0;
        i_efficiency    <= '0;
        i_three_phase   <= 1'b0;
        i_entry_index   <= '0;
        i_entry_power   <= '0;
        i_entry_current <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        send_idle_pct   = 10;
        recv_stall_pct  = 69;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole catalog ascending, then use all of it
        for (int i = 0; i < lce_pkg::CATALOG_DEPTH; i++) load_slot(i, sorted_power(i));
        set_catalog_size(7'd64);

        // directed formula cases
        send_item(lce_pkg::CMD_FORMULA, 32'sh7FFF_FFFF, 24'd1, 16'd1, 16'd1, 1'b0,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sh7FFF_FFFF, 24'hFF_FFFF, 16'd32768, 16'd32768,
                  1'b1, '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, '0, 24'd23000, 16'd29491, 16'd31130, 1'b1,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sh8000_0000, 24'd23000, 16'd29491, 16'd31130,
                  1'b0, '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sd256000, 24'd0, 16'd29491, 16'd31130, 1'b0,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sd256000, 24'd58880, 16'd0, 16'd31130, 1'b0,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sd256000, 24'd58880, 16'd32769, 16'd31130, 1'b0,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sd256000, 24'd58880, 16'd29491, 16'd0, 1'b1,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sd256000, 24'd58880, 16'd29491, 16'hFFFF, 1'b1,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_FORMULA, 32'sd2560000, 24'd102400, 16'd32768, 16'd32768,
                  1'b1, '0, '0, '0);
        send_item(lce_pkg::CMD_RSVD, 32'sd1, 24'd1, 16'd1, 16'd1, 1'b1, '0, '0, '0);

        // directed catalog cases: phase, sign, zero, both clamps, exact hit, interpolation
        send_item(lce_pkg::CMD_CATALOG, 32'sd1000, '0, '0, '0, 1'b0, '0, '0, '0);
        send_item(lce_pkg::CMD_CATALOG, -32'sd1, '0, '0, '0, 1'b1, '0, '0, '0);
        send_item(lce_pkg::CMD_CATALOG, '0, '0, '0, '0, 1'b1, '0, '0, '0);
        send_item(lce_pkg::CMD_CATALOG, 32'sd1, '0, '0, '0, 1'b1, '0, '0, '0);
        send_item(lce_pkg::CMD_CATALOG, 32'sh7FFF_FFFF, '0, '0, '0, 1'b1, '0, '0, '0);
        send_item(lce_pkg::CMD_CATALOG, $signed({1'b0, slot_power[20]}), '0, '0, '0, 1'b1,
                  '0, '0, '0);
        send_item(lce_pkg::CMD_CATALOG, $signed({1'b0, slot_power[20]}) + 32'sd1,
                  '0, '0, '0, 1'b1, '0, '0, '0);

        // unsorted table, then equal neighbours, then back in order
        load_slot(5, 31'h7FFF_FFFF);
        send_item(lce_pkg::CMD_CATALOG, 32'sd100000, '0, '0, '0, 1'b1, '0, '0, '0);
        load_slot(5, slot_power[4]);
        send_item(lce_pkg::CMD_CATALOG, $signed({1'b0, slot_power[4]}), '0, '0, '0, 1'b1,
                  '0, '0, '0);
        load_slot(5, sorted_power(5));

        // random part over several catalog sizes and idling profiles
        sizes = '{7'd1, 7'd0, 7'd127, 7'd2, 7'($urandom_range(3, 63)), 7'd64};
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct  = 69;
                recv_stall_pct = 10;
            end else if (seg == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            set_catalog_size(sizes[seg]);
            for (int n = 0; n < 200; n++) begin
                if (seg == 4 && n == 50) hold_req = 1'b1;
                random_item();
            end
        end

        // drain and decide
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[load_current_estimator] OK");
        end else begin
            $display("[load_current_estimator] ERROR");
        end
        $finish;
    end
endmodule

>>> load_current_estimator.f
+incdir+hw/rtl
hw/rtl/lce_pkg.sv
hw/rtl/lce_div.sv
hw/rtl/load_current_estimator.sv
tb/lce_result_checker.sv
tb/tb_top.sv
